[rtl/pdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_pkg: shared types and constants
// Function codes, status codes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int unsigned DestSlots   = 16;
  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned HandleBits  = 16;

  localparam logic [3:0]  LimitReset   = 4'd8;
  localparam logic [15:0] TimeoutReset = 16'd1000;

  localparam logic [1:0] FuncPush = 2'd0;
  localparam logic [1:0] FuncPop  = 2'd1;
  localparam logic [1:0] FuncTick = 2'd2;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatOvf     = 2'd1;
  localparam logic [1:0] StatFull    = 2'd2;
  localparam logic [1:0] StatMissing = 2'd3;

  localparam logic RegLimit   = 1'b0;
  localparam logic RegTimeout = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the input transaction
    logic scan;     // expire and search one slot
    logic scan_clr; // restart scan
    logic commit;   // apply push or pop update
    logic rd;       // read handle memory for pop
    logic fin;      // form the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage
`default_nettype wire

[rtl/pdq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_ctrl: sequencer
// Steps each transaction through load, slot scan, commit, read and result.
// ----------------------------------------------------------------------------
module pdq_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           out_busy_i,
  input  wire pdq_pkg::stat_t stat_i,
  output logic                in_ready_o,
  output pdq_pkg::cmd_t       cmd_o
);

  typedef enum logic [2:0] {StIdle, StScan, StCommit, StRead, StFin} state_e;
  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: if (in_fire_i) begin
        cmd_o.load = 1'b1; cmd_o.scan_clr = 1'b1; state_d = StScan;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1; state_d = StRead;
      end
      StRead: begin
        cmd_o.rd = 1'b1; state_d = StFin;
      end
      StFin: if (!out_busy_i) begin
        cmd_o.fin = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  // hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/pdq_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pdq_dp: slot table and handle store
// Scans slots one a cycle for expiry and match, then updates the queue.
// ----------------------------------------------------------------------------
module pdq_dp #(
  parameter int unsigned DEST_SLOTS  = pdq_pkg::DestSlots,
  parameter int unsigned QUEUE_DEPTH = pdq_pkg::QueueDepth,
  parameter int unsigned HANDLE_BITS = pdq_pkg::HandleBits
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pdq_pkg::cmd_t          cmd_i,
  output pdq_pkg::stat_t              stat_o,
  input  wire logic [1:0]             func_i,
  input  wire logic [31:0]            now_i,
  input  wire logic [47:0]            addr_i,
  input  wire logic [HANDLE_BITS-1:0] handle_i,
  input  wire logic [3:0]             limit_i,
  input  wire logic [15:0]            timeout_i,
  output logic [1:0]                  status_o,
  output logic                        hvalid_o,
  output logic [HANDLE_BITS-1:0]      popped_o,
  output logic [7:0]                  disc_o
);

  localparam int unsigned SW = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MD = DEST_SLOTS * QUEUE_DEPTH;
  localparam int unsigned MW = (MD > 1) ? $clog2(MD) : 1;

  // wrap a ring position that is below twice the depth
  function automatic logic [QW-1:0] qwrap(logic [QW:0] v);
    if (v >= (QW+1)'(QUEUE_DEPTH)) return QW'(v - (QW+1)'(QUEUE_DEPTH));
    return QW'(v);
  endfunction

  // slot table (per-slot registers, read at the scan index)
  logic [DEST_SLOTS-1:0] use_q;
  logic [47:0] addr_q [DEST_SLOTS];
  logic [31:0] dl_q   [DEST_SLOTS];
  logic [QW-1:0] head_q [DEST_SLOTS];
  logic [CW-1:0] cnt_q  [DEST_SLOTS];
  logic [HANDLE_BITS-1:0] mem_q [MD];

  logic [1:0]  func_q;
  logic [31:0] now_q;
  logic [47:0] key_q;
  logic [HANDLE_BITS-1:0] hnd_q;
  logic [SW:0] idx_q;
  logic        hit_q, free_q;
  logic [SW-1:0] hit_s_q, free_s_q;
  logic [7:0]  disc_q;
  logic [1:0]  st_q;
  logic        hv_q;
  logic [MW-1:0] raddr_q;
  logic [HANDLE_BITS-1:0] rdata_q;

  logic [SW-1:0] si;
  logic [31:0]   diff;
  logic          expire, scan_act;
  logic [8:0]    disc_sum;
  logic [CW-1:0] lim;

  assign si       = idx_q[SW-1:0];
  assign scan_act = (idx_q < (SW+1)'(DEST_SLOTS));
  assign stat_o.scan_done = !scan_act || (idx_q == (SW+1)'(DEST_SLOTS - 1));
  assign diff     = now_q - dl_q[si];
  assign expire   = ((func_q == pdq_pkg::FuncPush) || (func_q == pdq_pkg::FuncTick)) &&
                    use_q[si] && (diff != 32'd0) && !diff[31];
  assign disc_sum = {1'b0, disc_q} + 9'(cnt_q[si]);

  // effective limit, clamped to 1..QUEUE_DEPTH
  always_comb begin
    if (limit_i == 4'd0) lim = CW'(1);
    else if (32'(limit_i) > QUEUE_DEPTH) lim = CW'(QUEUE_DEPTH);
    else lim = CW'(limit_i);
  end

  logic [SW-1:0] ts;
  logic [QW-1:0] th;
  logic [CW-1:0] tc;
  logic          ovf;
  logic [QW-1:0] nh;
  logic [QW-1:0] wpos;
  assign ts   = hit_q ? hit_s_q : free_s_q;
  assign th   = hit_q ? head_q[ts] : '0;
  assign tc   = hit_q ? cnt_q[ts] : '0;
  assign ovf  = (tc >= lim);
  assign nh   = ovf ? qwrap({1'b0, th} + (QW+1)'(1)) : th;
  assign wpos = qwrap({1'b0, nh} + (QW+1)'(ovf ? tc - CW'(1) : tc));

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q <= '0;
      for (int i = 0; i < DEST_SLOTS; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      idx_q <= '0;
    end else begin
      if (cmd_i.scan_clr) idx_q <= '0;
      else if (cmd_i.scan && scan_act) idx_q <= idx_q + 1'b1;
      if (cmd_i.scan && scan_act && expire) begin
        use_q[si]  <= 1'b0;
        head_q[si] <= '0;
        cnt_q[si]  <= '0;
      end
      if (cmd_i.commit) begin
        if (func_q == pdq_pkg::FuncPush && (hit_q || free_q)) begin
          use_q[ts]  <= 1'b1;
          head_q[ts] <= nh;
          cnt_q[ts]  <= ovf ? tc : tc + CW'(1);
        end else if (func_q == pdq_pkg::FuncPop && hit_q && cnt_q[hit_s_q] != '0) begin
          if (cnt_q[hit_s_q] == CW'(1)) begin
            use_q[hit_s_q]  <= 1'b0;
            head_q[hit_s_q] <= '0;
          end else begin
            head_q[hit_s_q] <= qwrap({1'b0, head_q[hit_s_q]} + (QW+1)'(1));
          end
          cnt_q[hit_s_q] <= cnt_q[hit_s_q] - CW'(1);
        end
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i; now_q <= now_i; key_q <= addr_i; hnd_q <= handle_i;
      hit_q <= 1'b0; free_q <= 1'b0; disc_q <= '0; st_q <= pdq_pkg::StatOk;
      hv_q <= 1'b0;
    end
    if (cmd_i.scan && scan_act) begin
      if (expire) begin
        disc_q <= disc_sum[8] ? 8'hFF : disc_sum[7:0];
        if (!free_q) begin free_q <= 1'b1; free_s_q <= si; end
      end else if (use_q[si]) begin
        if (!hit_q && addr_q[si] == key_q) begin hit_q <= 1'b1; hit_s_q <= si; end
      end else if (!free_q) begin
        free_q <= 1'b1; free_s_q <= si;
      end
    end
    if (cmd_i.commit) begin
      unique case (func_q)
        pdq_pkg::FuncPush: begin
          if (hit_q || free_q) begin
            addr_q[ts] <= key_q;
            dl_q[ts]   <= now_q + 32'(timeout_i);
            mem_q[MW'(32'(ts) * QUEUE_DEPTH + 32'(wpos))] <= hnd_q;
            if (ovf) begin
              st_q <= pdq_pkg::StatOvf;
              disc_q <= (disc_q == 8'hFF) ? disc_q : disc_q + 8'd1;
            end
          end else begin
            st_q <= pdq_pkg::StatFull;
            disc_q <= (disc_q == 8'hFF) ? disc_q : disc_q + 8'd1;
          end
        end
        pdq_pkg::FuncPop: begin
          if (hit_q && cnt_q[hit_s_q] != '0) begin
            hv_q <= 1'b1;
            raddr_q <= MW'(32'(hit_s_q) * QUEUE_DEPTH + 32'(head_q[hit_s_q]));
          end else begin
            st_q <= pdq_pkg::StatMissing;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.rd) rdata_q <= mem_q[raddr_q];
    if (cmd_i.fin) begin
      status_o <= st_q;
      hvalid_o <= hv_q;
      popped_o <= hv_q ? rdata_q : '0;
      disc_o   <= disc_q;
    end
  end

endmodule
`default_nettype wire

[rtl/per_destination_packet_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// per_destination_packet_queue: per-destination handle FIFOs with timeout
// A transaction passes through load, the slot scan, commit, memory read and
// result; one item at a time, so no new input is taken until the result is
// formed. The slot scan checks one slot a cycle for expiry and match.
// Reset empties every slot and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module per_destination_packet_queue #(
  parameter int unsigned DEST_SLOTS  = pdq_pkg::DestSlots,
  parameter int unsigned QUEUE_DEPTH = pdq_pkg::QueueDepth,
  parameter int unsigned HANDLE_BITS = pdq_pkg::HandleBits
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // func[1:0], now_ms[33:2], dest_addr[81:34], packet_handle[97:82], zero pad
  input  wire logic [103:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], handle_valid[2], popped_handle[18:3], discarded_count[26:19], pad
  output logic [31:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic         cfg_idx_i,
  input  wire logic [15:0]  cfg_data_i
);

  pdq_pkg::cmd_t  cmd;
  pdq_pkg::stat_t stat;
  logic [3:0]  limit_q;
  logic [15:0] timeout_q;
  logic        in_fire, ovalid_q;
  logic [1:0]  status;
  logic        hvalid;
  logic [HANDLE_BITS-1:0] popped;
  logic [7:0]  disc;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= pdq_pkg::LimitReset;
      timeout_q <= pdq_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == pdq_pkg::RegLimit) limit_q <= cfg_data_i[3:0];
      else timeout_q <= cfg_data_i;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.fin) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  pdq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_busy_i(ovalid_q && !m_axis_tready),
    .stat_i(stat), .in_ready_o(s_axis_tready), .cmd_o(cmd)
  );

  pdq_dp #(.DEST_SLOTS(DEST_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH),
           .HANDLE_BITS(HANDLE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .func_i(s_axis_tdata[1:0]), .now_i(s_axis_tdata[33:2]),
    .addr_i(s_axis_tdata[81:34]), .handle_i(HANDLE_BITS'(s_axis_tdata[97:82])),
    .limit_i(limit_q), .timeout_i(timeout_q),
    .status_o(status), .hvalid_o(hvalid), .popped_o(popped), .disc_o(disc)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {5'd0, disc, 16'(popped), hvalid, status};

endmodule
`default_nettype wire

[tb/sv/per_destination_packet_queue_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_destination_packet_queue_tb: self-checking stream testbench
// Drives push, pop and tick transactions with random idling on both sides,
// mirrors the slot table, deadlines and handle FIFOs in a local model, and
// compares every result field against the oldest predicted result.
// ----------------------------------------------------------------------------
module per_destination_packet_queue_tb;

  localparam int unsigned NumSlots   = 16;
  localparam int unsigned Depth      = 8;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 40;

  // lowest field last, matching the result tdata layout
  typedef struct packed {
    logic [7:0]  discarded_count;
    logic [15:0] popped_handle;
    logic        handle_valid;
    logic [1:0]  status;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  per_destination_packet_queue DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  // Model of the slot table
  bit          slot_used [NumSlots];
  logic [47:0] slot_dest [NumSlots];
  logic [31:0] slot_due  [NumSlots];
  int unsigned slot_first[NumSlots];
  int unsigned slot_fill [NumSlots];
  logic [15:0] held_handles[NumSlots][Depth];
  logic [3:0]  limit_reg = pdq_pkg::LimitReset;
  logic [15:0] timeout_reg = pdq_pkg::TimeoutReset;

  result_t     pending_results[$];
  int unsigned mismatches = 0;
  bit          s_fire = 1'b0;
  bit          steady = 1'b0;      // no idling on either side
  int unsigned hold_off = 0;       // receiver stall cycles still to serve
  logic [31:0] clock_ms = 32'd0;
  logic [47:0] dest_pool[24];

  initial forever #5 clk_i = ~clk_i;

  // Expire every slot whose deadline lies strictly in the past
  function automatic int unsigned expire_slots(logic [31:0] now);
    int unsigned lost = 0;
    logic [31:0] diff;
    for (int s = 0; s < NumSlots; s++) begin
      diff = now - slot_due[s];
      if (slot_used[s] && diff != 0 && !diff[31]) begin
        lost += slot_fill[s];
        slot_used[s] = 1'b0;
        slot_first[s] = 0;
        slot_fill[s] = 0;
      end
    end
    return lost;
  endfunction

  function automatic int find_dest(logic [47:0] dest);
    for (int s = 0; s < NumSlots; s++)
      if (slot_used[s] && slot_dest[s] == dest) return s;
    return -1;
  endfunction

  // Work out the result of one accepted transaction and update the model
  function automatic result_t queue_model_step(logic [103:0] word);
    logic [1:0]  func = word[1:0];
    logic [31:0] now = word[33:2];
    logic [47:0] dest = word[81:34];
    logic [15:0] hnd = word[97:82];
    result_t     r = '0;
    int unsigned lost = 0;
    int unsigned lim;
    int          s;
    if (func == pdq_pkg::FuncPush) begin
      lost = expire_slots(now);
      s = find_dest(dest);
      if (s < 0) begin
        for (int f = 0; f < NumSlots; f++)
          if (!slot_used[f]) begin
            s = f;
            break;
          end
        if (s >= 0) begin
          slot_used[s] = 1'b1;
          slot_dest[s] = dest;
          slot_first[s] = 0;
          slot_fill[s] = 0;
        end
      end
      if (s < 0) begin
        r.status = pdq_pkg::StatFull;
        lost += 1;
      end else begin
        lim = (limit_reg == 0) ? 1 : (limit_reg > Depth) ? Depth : limit_reg;
        if (slot_fill[s] >= lim) begin
          slot_first[s] = (slot_first[s] + 1) % Depth;
          slot_fill[s] -= 1;
          r.status = pdq_pkg::StatOvf;
          lost += 1;
        end
        held_handles[s][(slot_first[s] + slot_fill[s]) % Depth] = hnd;
        slot_fill[s] += 1;
        slot_due[s] = now + {16'd0, timeout_reg};
      end
    end else if (func == pdq_pkg::FuncPop) begin
      s = find_dest(dest);
      if (s < 0 || slot_fill[s] == 0) begin
        r.status = pdq_pkg::StatMissing;
      end else begin
        r.popped_handle = held_handles[s][slot_first[s]];
        r.handle_valid = 1'b1;
        slot_first[s] = (slot_first[s] + 1) % Depth;
        slot_fill[s] -= 1;
        if (slot_fill[s] == 0) begin
          slot_used[s] = 1'b0;
          slot_first[s] = 0;
        end
      end
    end else if (func == pdq_pkg::FuncTick) begin
      lost = expire_slots(now);
    end
    r.discarded_count = (lost > 255) ? 8'd255 : lost[7:0];
    return r;
  endfunction

  // Record the handshake and predict on every input transaction
  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready)
      pending_results.push_back(queue_model_step(s_axis_tdata));
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[26:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status %0d/%0d valid %0d/%0d handle %h/%h count %0d/%0d",
                     want.status, got.status, want.handle_valid, got.handle_valid,
                     want.popped_handle, got.popped_handle,
                     want.discarded_count, got.discarded_count);
        end
      end
    end
  end

  // Receiver: random idling, long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 22);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(logic [1:0] func, logic [31:0] now, logic [47:0] dest,
                           logic [15:0] hnd);
    if (!steady && $urandom_range(99) < 22) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, hnd, dest, now, func};
    do @(negedge clk_i); while (!s_fire);
  endtask

  // Stop offering and wait for every result, then let the block settle
  task automatic drain;
    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == pdq_pkg::RegLimit) limit_reg = value[3:0];
    else timeout_reg = value;
  endtask

  // Random transaction mostly aimed at the address pool
  task automatic send_random(int unsigned max_step);
    int unsigned pick = $urandom_range(99);
    logic [47:0] dest;
    dest = ($urandom_range(19) == 0) ? 48'({$urandom, $urandom})
                                     : dest_pool[$urandom_range(23)];
    if ($urandom_range(49) == 0) clock_ms += $urandom;
    else clock_ms += $urandom_range(max_step);
    send_item(pick < 55 ? pdq_pkg::FuncPush : pick < 85 ? pdq_pkg::FuncPop : pdq_pkg::FuncTick,
              clock_ms, dest, 16'($urandom));
  endtask

  task automatic test_directed;
    send_item(pdq_pkg::FuncPop, 32'd0, 48'd0, 16'd0);
    send_item(pdq_pkg::FuncPush, 32'd0, 48'd0, 16'h0000);
    send_item(pdq_pkg::FuncPush, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    send_item(pdq_pkg::FuncPop, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0);
    send_item(pdq_pkg::FuncPop, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd0);
    // overflow one destination past the default limit
    for (int i = 0; i < 10; i++)
      send_item(pdq_pkg::FuncPush, 32'd10, 48'h0000_0000_0001, 16'(16'h1000 + i));
    send_item(pdq_pkg::FuncPop, 32'd10, 48'h0000_0000_0001, 16'd0);
    // tick without and with expiry
    send_item(pdq_pkg::FuncTick, 32'd500, 48'd0, 16'd0);
    send_item(pdq_pkg::FuncTick, 32'd2000, 48'hAAAA_5555_AAAA, 16'h5A5A);
    send_item(pdq_pkg::FuncPop, 32'd2000, 48'h0000_0000_0001, 16'd0);
  endtask

  task automatic test_table_full;
    for (int i = 0; i < 18; i++)
      send_item(pdq_pkg::FuncPush, 32'd3000, 48'h1234_0000_0000 + i, 16'(i));
    for (int i = 0; i < 18; i++)
      send_item(pdq_pkg::FuncPop, 32'd3000, 48'h1234_0000_0000 + i, 16'd0);
  endtask

  // Deadlines that straddle the 32-bit wrap of the millisecond clock
  task automatic test_time_wrap;
    write_reg(pdq_pkg::RegTimeout, 16'd1);
    send_item(pdq_pkg::FuncPush, 32'hFFFF_FFFF, 48'h0000_0000_0002, 16'h00AA);
    send_item(pdq_pkg::FuncTick, 32'd0, 48'd0, 16'd0);
    send_item(pdq_pkg::FuncTick, 32'd1, 48'd0, 16'd0);
    write_reg(pdq_pkg::RegTimeout, 16'hFFFF);
    send_item(pdq_pkg::FuncPush, 32'hFFFF_8000, 48'h0000_0000_0003, 16'h00BB);
    send_item(pdq_pkg::FuncTick, 32'h0000_7FFF, 48'd0, 16'd0);
    send_item(pdq_pkg::FuncTick, 32'h0000_8000, 48'd0, 16'd0);
  endtask

  // Stall the receiver so the block fills and holds off its input
  task automatic test_backpressure;
    hold_off = 600;
    for (int i = 0; i < 12; i++) send_random(50);
    drain();
  endtask

  task automatic test_random;
    logic [3:0]  limits[6] = '{4'd0, 4'd1, 4'd3, 4'd8, 4'd15, 4'd5};
    logic [15:0] timeouts[6] = '{16'd1, 16'd60, 16'd300, 16'd1000, 16'hFFFF, 16'd20};
    for (int p = 0; p < 6; p++) begin
      write_reg(pdq_pkg::RegLimit, 16'(limits[p]));
      write_reg(pdq_pkg::RegTimeout, timeouts[p]);
      if (p == 2) clock_ms = 32'hFFFF_F000;
      steady = (p == 3);
      for (int i = 0; i < 210; i++)
        send_random(timeouts[p] < 16'd20 ? 2 : timeouts[p] / 8);
      steady = 1'b0;
    end
  endtask

  initial begin
    for (int i = 0; i < 24; i++) dest_pool[i] = 48'({$urandom, $urandom});
    dest_pool[0] = 48'd0;
    dest_pool[1] = 48'hFFFF_FFFF_FFFF;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_table_full();
    test_time_wrap();
    write_reg(pdq_pkg::RegLimit, 16'd8);
    write_reg(pdq_pkg::RegTimeout, 16'd1000);
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
